>>> hdl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants and types for the sorted-table binary search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // Fixed widths of the port fields.
    localparam int FIELD_WIDTH = 32;
    localparam int INDEX_WIDTH = 10;
    localparam int COUNT_WIDTH = 11;
    localparam int POS_WIDTH   = 10;

    // Operation codes of an input word.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Result handed from the search engine to the output register.
    typedef struct packed {
        logic                 found;
        logic [POS_WIDTH-1:0] position;
    } result_t;

endpackage

>>> hdl/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Table of signed entries with binary search over its leading entries.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one word per item. A write
// word (operation 0) stores entry_value at entry_index and gives no result.
// A search word (operation 1) looks for search_key in
// entries 0 to used_entries-1 and gives one result word on the output
// channel (out_valid/out_ready) with found and position.
// A search holds the engine until its result word moves on. It makes P
// probes, at most floor(log2(used_entries)) + 1 (11 for a full table of
// 1024). Each probe is one synchronous read of the table memory followed by
// one compare. The result word reaches out_valid through the output register.
// used_entries is written through cfg_valid/cfg_data and is taken at once.
// Reset clears the control state and used_entries; the table memory is not
// cleared, and entries must be written before a search reaches them.
// An output register holds a finished result while the receiver stalls, so
// the next word is accepted; a second result waits in the engine until the
// output register frees up.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = stbs_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [stbs_pkg::COUNT_WIDTH-1:0] cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   operation,
    input  logic        [stbs_pkg::INDEX_WIDTH-1:0] entry_index,
    input  logic signed [stbs_pkg::FIELD_WIDTH-1:0] entry_value,
    input  logic signed [stbs_pkg::FIELD_WIDTH-1:0] search_key,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   found,
    output logic        [stbs_pkg::POS_WIDTH-1:0]   position
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [stbs_pkg::COUNT_WIDTH-1:0] used_entries_reg;
    logic [31:0]                      used_wide;
    logic [31:0]                      used_sat;
    logic [CW-1:0]                    used_count;
    logic                             out_valid_reg;
    stbs_pkg::result_t                out_reg;
    stbs_pkg::result_t                res;
    logic                             res_valid;
    logic                             res_ready;

    assign cfg_ready = 1'b1;

    // A count above the table depth covers the whole table.
    assign used_wide  = 32'(used_entries_reg);
    assign used_sat   = (used_wide > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : used_wide;
    assign used_count = used_sat[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_entries_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            used_entries_reg <= cfg_data;
        end
    end

    stbs_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CW          (CW)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .used_count  (used_count),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = out_reg.found;
    assign position  = out_reg.position;

endmodule

>>> hdl/stbs_engine.sv
// ----------------------------------------------------------------------------
// stbs_engine
// Table memory and the probe sequencer: writes entries and runs one binary
// search at a time, one synchronous memory read per probe.
// ----------------------------------------------------------------------------
module stbs_engine #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = stbs_pkg::DEFAULT_VALUE_WIDTH,
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   operation,
    input  logic        [stbs_pkg::INDEX_WIDTH-1:0] entry_index,
    input  logic signed [stbs_pkg::FIELD_WIDTH-1:0] entry_value,
    input  logic signed [stbs_pkg::FIELD_WIDTH-1:0] search_key,
    input  logic        [CW-1:0]                   used_count,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output stbs_pkg::result_t                      res
);

    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_PUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [AW-1:0] mid_reg;
    logic [AW-1:0] mid;
    logic [CW-1:0] span;
    logic [CW-1:0] mid_wide;
    logic [CW-1:0] mid_plus;
    logic signed [VALUE_WIDTH-1:0] key_reg;
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;
    logic signed [VALUE_WIDTH-1:0] table_mem [TABLE_DEPTH];
    stbs_pkg::result_t res_reg, res_next;

    logic                          accept;
    logic                          wr_en;
    logic [31:0]                   idx_wide;
    logic [AW-1:0]                 wr_addr;
    logic signed [63:0]            value_ext;
    logic signed [63:0]            key_ext;
    logic [31:0]                   mid_ext;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_PUSH);
    assign res       = res_reg;

    // Values are sign-extended and then kept in their low VALUE_WIDTH bits.
    assign value_ext = 64'(entry_value);
    assign key_ext   = 64'(search_key);
    assign idx_wide  = 32'(entry_index);
    assign wr_addr   = idx_wide[AW-1:0];
    assign wr_en     = accept && (operation == stbs_pkg::OP_WRITE)
                       && (idx_wide < 32'(TABLE_DEPTH));

    // Probe address; lo < hi holds whenever this is used.
    assign span     = hi_reg - lo_reg - CW'(1);
    assign mid_wide = lo_reg + (span >> 1);
    assign mid      = mid_wide[AW-1:0];
    assign mid_plus = CW'(mid_reg) + CW'(1);
    assign mid_ext  = 32'(mid_reg);

    // Writes are only taken while no search runs, so a read never meets a
    // write to the same entry and no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= value_ext[VALUE_WIDTH-1:0];
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= table_mem[mid];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == stbs_pkg::OP_SEARCH))
                begin
                    lo_next  = '0;
                    hi_next  = used_count;
                    res_next = '0;
                    if (used_count == '0)
                    begin
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    res_next.found    = 1'b1;
                    res_next.position = mid_ext[stbs_pkg::POS_WIDTH-1:0];
                    state_next        = ST_PUSH;
                end
                else
                begin
                    if (rd_data_reg < key_reg)
                    begin
                        lo_next = mid_plus;
                    end
                    else
                    begin
                        hi_next = CW'(mid_reg);
                    end
                    if (lo_next < hi_next)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        res_reg <= res_next;
        if (state_reg == ST_READ)
        begin
            mid_reg <= mid;
        end
        if (accept && (operation == stbs_pkg::OP_SEARCH))
        begin
            key_reg <= key_ext[VALUE_WIDTH-1:0];
        end
    end

endmodule

>>> hdl/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks for the sorted-table binary search core, bound to it.
// ----------------------------------------------------------------------------
module stbs_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 operation,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 found,
    input logic        [stbs_pkg::POS_WIDTH-1:0] position
);

    // A stalled result word keeps its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position))
        else $error("stalled result word changed or dropped");

    // A missed key always reports position zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> position == '0)
        else $error("not-found result with nonzero position");

    // A search word occupies the engine, so the next word waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == stbs_pkg::OP_SEARCH |=> !in_ready)
        else $error("input taken right after a search word");

    // A search result never appears in the cycle right after the search.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == stbs_pkg::OP_SEARCH |=> !$rose(out_valid))
        else $error("result word appeared too early");

    // A write word finishes at once and the input stays open.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == stbs_pkg::OP_WRITE |=> in_ready)
        else $error("write word stalled the input");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (.*);

>>> tb/sorted_table_binary_search_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core_tb
// Self-checking testbench for the sorted-table binary search core. Table
// writes and key searches are sent through the input channel. A local copy
// of the table predicts the probe sequence of each search. Every result word
// is compared against the oldest prediction. Sender bursts and receiver
// stalls are randomized, and the search span register is rewritten between
// phases while the core is idle.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core_tb;

    localparam int DEPTH         = stbs_pkg::DEFAULT_TABLE_DEPTH;
    localparam int FW            = stbs_pkg::FIELD_WIDTH;
    localparam int IW            = stbs_pkg::INDEX_WIDTH;
    localparam int CNTW          = stbs_pkg::COUNT_WIDTH;
    localparam int PW            = stbs_pkg::POS_WIDTH;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 50;
    localparam int RANDOM_WORDS  = 70;
    localparam logic signed [FW-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [FW-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_LONG_STALL} rx_mode_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CNTW-1:0]      cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 operation   = stbs_pkg::OP_WRITE;
    logic [IW-1:0]        entry_index = '0;
    logic signed [FW-1:0] entry_value = '0;
    logic signed [FW-1:0] search_key  = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic                 found;
    logic [PW-1:0]        position;

    // Local copy of the table and of the span register.
    logic signed [FW-1:0] entry_mem [DEPTH];
    logic [CNTW-1:0]      span_count;
    stbs_pkg::result_t    pending_results[$];

    int       fail_count   = 0;
    int       cycle_count  = 0;
    int       burst_left   = 0;
    int       gap_max      = 4;
    int       random_words = 0;
    rx_mode_t rx_mode      = RX_ALWAYS;
    int       rx_mode_left = 0;
    int       rx_stall     = 0;

    sorted_table_binary_search_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .position    (position)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Follows the probe sequence over the first span_count entries.
    function automatic stbs_pkg::result_t predict_search(input logic signed [FW-1:0] key);
        int                lo_idx;
        int                hi_idx;
        int                mid;
        stbs_pkg::result_t r;
        r = '0;
        lo_idx = 0;
        hi_idx = (span_count > DEPTH) ? DEPTH : int'(span_count);
        while (lo_idx < hi_idx)
        begin
            mid = lo_idx + (hi_idx - 1 - lo_idx) / 2;
            if (entry_mem[mid] == key)
            begin
                r.found = 1'b1;
                r.position = PW'(mid);
                return r;
            end
            if (entry_mem[mid] < key)
                lo_idx = mid + 1;
            else
                hi_idx = mid;
        end
        return r;
    endfunction

    task automatic send_word(input logic op, input logic [IW-1:0] idx,
                             input logic signed [FW-1:0] value,
                             input logic signed [FW-1:0] key);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        entry_index <= idx;
        entry_value <= value;
        search_key  <= key;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        if (op == stbs_pkg::OP_WRITE)
            entry_mem[idx] = value;
        else
            pending_results.push_back(predict_search(key));
    endtask

    task automatic write_entry(input int idx, input logic signed [FW-1:0] value);
        send_word(stbs_pkg::OP_WRITE, IW'(idx), value, $urandom);
    endtask

    task automatic search_for(input logic signed [FW-1:0] key);
        send_word(stbs_pkg::OP_SEARCH, IW'($urandom), $urandom, key);
    endtask

    // The span register is only written once the core has drained.
    task automatic write_span(input int count);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CNTW'(count);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        span_count = CNTW'(count);
    endtask

    // Writes entries 0 .. count-1 with a non-decreasing sequence.
    task automatic fill_sorted(input int count, input longint first,
                               input int unsigned step_max);
        longint v;
        v = first;
        for (int i = 0; i < count; i++)
        begin
            if (v > longint'(VALUE_MAX))
                v = VALUE_MAX;
            write_entry(i, FW'(v));
            v += $urandom_range(0, step_max);
        end
    endtask

    task automatic test_empty_table();
        search_for(VALUE_MIN);
        write_span(0);
        search_for(VALUE_MAX);
        search_for(0);
    endtask

    task automatic test_small_table();
        write_entry(0, VALUE_MIN);
        write_entry(1, -5);
        write_entry(2, -1);
        write_entry(3, 0);
        write_entry(4, 0);
        write_entry(5, 7);
        write_entry(6, 1000);
        write_entry(7, VALUE_MAX);
        write_span(8);
        search_for(VALUE_MIN);
        search_for(VALUE_MAX);
        search_for(7);
        search_for(0);
        search_for(3);
        search_for(VALUE_MIN + 1);
        search_for(-6);
        write_span(1);
        search_for(VALUE_MIN);
        search_for(5);
        // Break the ordering and let the probe sequence run over it.
        write_entry(3, 2000);
        write_span(8);
        search_for(1000);
        search_for(2000);
    endtask

    task automatic test_full_table();
        gap_max = 3;
        fill_sorted(DEPTH, longint'(VALUE_MIN), 8000000);
        write_entry(DEPTH - 1, VALUE_MAX);
        write_span(DEPTH);
        search_for(entry_mem[0]);
        search_for(entry_mem[DEPTH - 1]);
        search_for(entry_mem[DEPTH / 2 - 1]);
        search_for(entry_mem[$urandom_range(0, DEPTH - 1)]);
        search_for($urandom);
        // Counts above the table depth cover the whole table.
        write_span(2047);
        search_for(entry_mem[DEPTH - 1]);
        search_for(entry_mem[$urandom_range(0, DEPTH - 1)]);
        search_for($urandom);
        write_span(DEPTH + 1);
        search_for(entry_mem[0]);
        search_for(entry_mem[$urandom_range(0, DEPTH - 1)] + 1);
    endtask

    task automatic test_random_phases();
        int                   n;
        int                   m;
        int                   pick;
        int                   idx;
        longint               lo_b;
        longint               hi_b;
        logic signed [FW-1:0] key;
        while (random_words < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                n = $urandom_range(1, 40);
            else if (pick < 85)
                n = $urandom_range(41, DEPTH);
            else if (pick < 90)
                n = 0;
            else if (pick < 95)
                n = DEPTH;
            else
                n = $urandom_range(DEPTH + 1, 2047);
            write_span(n);
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            m = (n > DEPTH) ? DEPTH : n;
            if (m != 0 && m <= 64 && $urandom_range(0, 3) == 0)
            begin
                fill_sorted(m, longint'($signed($urandom)),
                            ($urandom_range(0, 1) == 0) ? 3 : 50000000);
                random_words += m;
            end
            repeat ($urandom_range(10, 40))
            begin
                pick = $urandom_range(0, 99);
                idx = (m == 0) ? 0 : $urandom_range(0, m - 1);
                if (pick < 60 && m != 0)
                    search_for(entry_mem[idx]);
                else if (pick < 75)
                begin
                    case ($urandom_range(0, 3))
                        0: key = $urandom;
                        1: key = entry_mem[idx] + 1;
                        2: key = entry_mem[idx] - 1;
                        default: key = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
                    endcase
                    search_for(key);
                end
                else if (pick < 90 && m != 0)
                begin
                    // Keep the searched range in order.
                    lo_b = (idx == 0) ? longint'(VALUE_MIN) : longint'(entry_mem[idx - 1]);
                    hi_b = (idx == m - 1) ? longint'(VALUE_MAX) : longint'(entry_mem[idx + 1]);
                    if (lo_b > hi_b)
                        write_entry(idx, FW'(lo_b));
                    else
                        write_entry(idx, FW'(lo_b +
                                    $urandom_range(0, int'(hi_b - lo_b))));
                end
                else
                    write_entry($urandom_range(0, DEPTH - 1), $urandom);
                random_words++;
            end
        end
    endtask

    // Receiver: ready all the time, on a coin toss, or with long stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(64, 256);
            end
            else
                rx_mode_left--;
            case (rx_mode)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (rx_stall != 0)
                    begin
                        rx_stall--;
                        out_ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        rx_stall = $urandom_range(1, 30);
                        out_ready <= 1'b0;
                    end
                    else
                        out_ready <= 1'b1;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin : check_result
        stbs_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with none expected: found %0b position %0d",
                         $time, found, position);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, found);
                    fail_count++;
                end
                if (position !== want.position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, position);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        span_count = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_small_table();
        test_full_table();
        test_random_phases();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/stbs_pkg.sv
hdl/stbs_engine.sv
hdl/sorted_table_binary_search_core.sv
hdl/stbs_checker.sv
tb/sorted_table_binary_search_core_tb.sv
